>>> hdl/four_class_strict_priority_queue_defines.svh
// Assertion macros for the four-class strict-priority queue.
`ifndef FOUR_CLASS_STRICT_PRIORITY_QUEUE_DEFINES_SVH
`define FOUR_CLASS_STRICT_PRIORITY_QUEUE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define FCSPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define FCSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fcspq_pkg.sv
// Package: types and constants of the four-class strict-priority queue.
`default_nettype none

package fcspq_pkg;

    localparam int NUM_CLASSES         = 4;
    localparam int CLASS_W             = 2;
    localparam int ITEM_ID_W           = 16;
    localparam int TICKET_W            = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_ID_WIDTH    = 16;

    // Input tdata: service_class, item_id; padded to whole bytes.
    localparam int S_FIELDS_W = CLASS_W + ITEM_ID_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 1;

    // Output tdata: out_item_id, out_ticket, out_class, next_ticket.
    localparam int M_FIELDS_W = ITEM_ID_W + TICKET_W + CLASS_W + TICKET_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> hdl/four_class_strict_priority_queue.sv
// Four-class strict-priority queue: top level.
//
// Usage:
//   Slave channel i_s_*: one command per item. tuser holds the command
//   (enqueue or dequeue); tdata holds service_class and item_id.
//   Master channel o_m_*: one result per command. tuser holds the status;
//   tdata holds out_item_id, out_ticket, out_class and next_ticket.
//   Result: a result is registered and valid in the cycle after its command is accepted.
//   Throughput: one command per cycle while the receiver keeps up; the queue
//   storage has one write port and one read port with registered read data,
//   and every command makes at most one access to each.
//   Reset: head pointers, fill counts and the ticket counter clear at once;
//   the entry storage is not cleared, so the block is ready right after reset.
//   Stall: when the receiver holds i_m_tready low, the result register holds
//   and o_s_tready drops until the result is taken.
//   A full class rejects an enqueue without using a ticket.
`default_nettype none
`include "four_class_strict_priority_queue_defines.svh"

module four_class_strict_priority_queue #(
    parameter int QUEUE_DEPTH = fcspq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_WIDTH    = fcspq_pkg::DEFAULT_ID_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [1:0] service_class, [17:2] item_id, rest zero
    input  wire logic [fcspq_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] command
    input  wire logic [fcspq_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [15:0] out_item_id, [31:16] out_ticket, [33:32] out_class,
    // [49:34] next_ticket, rest zero
    output logic [fcspq_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // [1:0] status
    output logic [fcspq_pkg::M_TUSER_W-1:0]      o_m_tuser
);

    import fcspq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W  = (ID_WIDTH < ITEM_ID_W) ? ID_WIDTH : ITEM_ID_W;
    localparam int ENT_W = ID_W + TICKET_W;
    localparam int PAD_W = M_TDATA_W - M_FIELDS_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    // Queue state
    logic [PTR_W-1:0]    r_head  [NUM_CLASSES];
    logic [PTR_W-1:0]    n_head  [NUM_CLASSES];
    logic [CNT_W-1:0]    r_count [NUM_CLASSES];
    logic [CNT_W-1:0]    n_count [NUM_CLASSES];
    logic [TICKET_W-1:0] r_ticket;
    logic [TICKET_W-1:0] n_ticket;
    logic [ENT_W-1:0]    r_mem [NUM_CLASSES][QUEUE_DEPTH];

    // Result register
    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic [CLASS_W-1:0]  r_class;
    logic [CLASS_W-1:0]  n_class;
    logic [TICKET_W-1:0] r_res_ticket;
    logic [TICKET_W-1:0] n_res_ticket;
    logic [TICKET_W-1:0] r_next_ticket;
    logic                r_deq_ok;
    logic [ENT_W-1:0]    r_rd_data;

    logic                w_accept;
    t_cmd                w_cmd;
    logic [CLASS_W-1:0]  w_cls;
    logic [ID_W-1:0]     w_id;
    logic                w_enq_ok;
    logic                w_deq_ok;
    logic                w_found;
    logic [CLASS_W-1:0]  w_sel_cls;
    logic [CNT_W:0]      w_tail_sum;
    logic [PTR_W-1:0]    w_wr_ptr;
    logic [ITEM_ID_W-1:0] w_out_id;
    logic [TICKET_W-1:0] w_out_ticket;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cmd      = t_cmd'(i_s_tuser[0]);
    assign w_cls      = i_s_tdata[CLASS_W-1:0];
    assign w_id       = i_s_tdata[CLASS_W +: ID_W];

    always_comb begin
        w_found   = 1'b0;
        w_sel_cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_count[c] != '0) begin
                w_found   = 1'b1;
                w_sel_cls = CLASS_W'(c);
            end
        end
    end

    always_comb begin
        w_tail_sum = (CNT_W + 1)'(r_head[w_cls]) + (CNT_W + 1)'(r_count[w_cls]);
        if (w_tail_sum >= DEPTH_SUM) begin
            w_tail_sum = w_tail_sum - DEPTH_SUM;
        end
        w_wr_ptr = w_tail_sum[PTR_W-1:0];
    end

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_ticket     = r_ticket;
        n_status     = ST_OK;
        n_class      = '0;
        n_res_ticket = '0;
        w_enq_ok     = 1'b0;
        w_deq_ok     = 1'b0;
        unique case (w_cmd)
            CMD_ENQ: begin
                n_class = w_cls;
                if (r_count[w_cls] == DEPTH_CNT) begin
                    n_status = ST_FULL;
                end else begin
                    w_enq_ok         = 1'b1;
                    n_ticket         = r_ticket + 1'b1;
                    n_count[w_cls]   = r_count[w_cls] + 1'b1;
                    n_res_ticket     = n_ticket;
                end
            end
            CMD_DEQ: begin
                if (!w_found) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_deq_ok           = 1'b1;
                    n_class            = w_sel_cls;
                    n_count[w_sel_cls] = r_count[w_sel_cls] - 1'b1;
                    n_head[w_sel_cls]  = (r_head[w_sel_cls] == LAST_PTR) ? '0
                                       : r_head[w_sel_cls] + 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
            r_ticket    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_ticket    <= n_ticket;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_class       <= n_class;
            r_res_ticket  <= n_res_ticket;
            r_next_ticket <= n_ticket + 1'b1;
            r_deq_ok      <= w_deq_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_enq_ok) begin
            r_mem[w_cls][w_wr_ptr] <= {n_ticket, w_id};
        end
        if (w_accept) begin
            r_rd_data <= r_mem[w_sel_cls][r_head[w_sel_cls]];
        end
    end

    always_comb begin
        w_out_id = '0;
        if (r_deq_ok) begin
            w_out_id[ID_W-1:0] = r_rd_data[ID_W-1:0];
        end
        w_out_ticket = r_deq_ok ? r_rd_data[ENT_W-1:ID_W] : r_res_ticket;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_next_ticket, r_class, w_out_ticket, w_out_id};

    `FCSPQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count[0] <= DEPTH_CNT && r_count[1] <= DEPTH_CNT &&
        r_count[2] <= DEPTH_CNT && r_count[3] <= DEPTH_CNT,
        "fill count beyond queue depth")
    `FCSPQ_ASSERT_NEXT(a_full_reject, i_clk, i_rst_n,
        w_accept && w_cmd == CMD_ENQ && r_count[w_cls] == DEPTH_CNT,
        o_m_tuser == ST_FULL && $stable(r_ticket), "full enqueue not rejected")
    `FCSPQ_ASSERT_NEXT(a_empty_deq, i_clk, i_rst_n,
        w_accept && w_cmd == CMD_DEQ && !w_found,
        o_m_tuser == ST_EMPTY && o_m_tdata[ITEM_ID_W-1:0] == '0, "empty dequeue misreported")
    `FCSPQ_ASSERT_NEXT(a_ticket_hold, i_clk, i_rst_n, !(w_accept && w_enq_ok),
        $stable(r_ticket), "ticket counter moved without an enqueue")

endmodule

`default_nettype wire
